// ----- src/cgc_pkg.sv -----
package cgc_pkg;

    localparam int COORD_BITS     = 16;
    localparam int OUT_IDX_BITS   = 13;
    localparam int SUM_BITS       = 28;
    localparam int FACTOR_BITS    = 8;
    localparam int PADDR_BITS     = 4;
    localparam int PDATA_BITS     = 32;

    localparam int MAX_RANGE_DEF      = 8;
    localparam int MAX_COMPONENTS_DEF = 4096;

    // register indexes, word address bits [3:2]
    localparam logic [1:0] REG_MAX_RANGE    = 2'd0;
    localparam logic [1:0] REG_MAX_GAP      = 2'd1;
    localparam logic [1:0] REG_MAX_ASPECT   = 2'd2;
    localparam logic [1:0] REG_WIDTH_FACTOR = 2'd3;

    localparam logic [3:0] RST_MAX_RANGE    = 4'd4;
    localparam logic [9:0] RST_MAX_GAP      = 10'd2;
    localparam logic [7:0] RST_MAX_ASPECT   = 8'd40;
    localparam logic [7:0] RST_WIDTH_FACTOR = 8'd40;

    typedef struct packed {
        logic [OUT_IDX_BITS-1:0] first_comp;
        logic [OUT_IDX_BITS-1:0] last_comp;
        logic [COORD_BITS-1:0]   left;
        logic [COORD_BITS-1:0]   top;
        logic [COORD_BITS-1:0]   right;
        logic [COORD_BITS-1:0]   bottom;
    } t_group;

endpackage

// ----- src/component_group_candidates.sv -----
// channel   | handshake          | payload
// ----------+--------------------+----------------------------------------------------
// box in    | i_valid / o_stall  | i_mode i_left i_top i_right i_bottom i_final_box
// group out | o_valid / i_stall  | o_first_component o_last_component o_group_* o_last
// config    | psel penable pwrite| paddr pwdata prdata pready (always high)
//
// a height pass box is summed while idle; a grouping box goes through setup (SETUP, THR),
// then per box walked a window read and union update (READ, ACC), MULA, MULB and CHK for a
// group of two or more (shared multiplier for the aspect and width tests), EMIT when a group
// is kept, and FLUSH to finish; one window read port and the single shared multiplier set this order
// reset is synchronous, active low, loads the configuration defaults and clears sums, counts and window fill
// o_stall is high while a grouping box is in work; a stalled output only holds the walk
// when a second kept group is ready or at the finish
module component_group_candidates
    import cgc_pkg::*;
#(
    parameter int MAX_RANGE      = MAX_RANGE_DEF,
    parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_BITS-1:0]   paddr,
    input  logic [PDATA_BITS-1:0]   pwdata,
    output logic [PDATA_BITS-1:0]   prdata,
    output logic                    pready,

    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_mode,
    input  logic [COORD_BITS-1:0]   i_left,
    input  logic [COORD_BITS-1:0]   i_top,
    input  logic [COORD_BITS-1:0]   i_right,
    input  logic [COORD_BITS-1:0]   i_bottom,
    input  logic                    i_final_box,

    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OUT_IDX_BITS-1:0] o_first_component,
    output logic [OUT_IDX_BITS-1:0] o_last_component,
    output logic [COORD_BITS-1:0]   o_group_left,
    output logic [COORD_BITS-1:0]   o_group_top,
    output logic [COORD_BITS-1:0]   o_group_right,
    output logic [COORD_BITS-1:0]   o_group_bottom,
    output logic                    o_last
);

    localparam int CNT_BITS = $clog2(MAX_COMPONENTS + 1);
    localparam int IW       = (CNT_BITS > OUT_IDX_BITS) ? CNT_BITS : OUT_IDX_BITS;
    localparam int FW       = $clog2(MAX_RANGE + 1);
    localparam int PW       = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;
    localparam int MB       = (CNT_BITS > FACTOR_BITS) ? CNT_BITS : FACTOR_BITS;
    localparam int PRODW    = SUM_BITS + MB;
    localparam int THRW     = SUM_BITS + FACTOR_BITS;
    localparam int BOXW     = 4 * COORD_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SETUP = 10'b0000000010,
        S_THR   = 10'b0000000100,
        S_READ  = 10'b0000001000,
        S_ACC   = 10'b0000010000,
        S_MULA  = 10'b0000100000,
        S_MULB  = 10'b0001000000,
        S_CHK   = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_FLUSH = 10'b1000000000
    } t_state;

    function automatic logic [PW-1:0] win_addr(input logic [PW-1:0] base,
                                               input logic [PW-1:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PW+1)'(MAX_RANGE)) begin
            sum = sum - (PW+1)'(MAX_RANGE);
        end
        return sum[PW-1:0];
    endfunction

    // configuration
    logic [3:0]              r_max_range, n_max_range;
    logic [9:0]              r_max_gap, n_max_gap;
    logic [7:0]              r_max_aspect, n_max_aspect;
    logic [7:0]              r_width_factor, n_width_factor;

    // pass state
    logic [SUM_BITS-1:0]     r_height_sum, n_height_sum;
    logic [CNT_BITS-1:0]     r_box_count, n_box_count;
    logic [FW-1:0]           r_fill, n_fill;
    logic [PW-1:0]           r_head, n_head;
    logic [CNT_BITS-1:0]     r_gpi, n_gpi;

    logic [BOXW-1:0]         r_win [MAX_RANGE];
    logic [BOXW-1:0]         r_rd;

    // sequencer
    t_state                  r_state, n_state;
    logic                    r_fin, n_fin;
    logic                    r_stored, n_stored;
    logic [PW-1:0]           r_p_start, n_p_start;
    logic [PW-1:0]           r_p_cur, n_p_cur;
    logic [PW-1:0]           r_p_last, n_p_last;
    logic [PW-1:0]           r_p_end, n_p_end;
    logic [IW-1:0]           r_s, n_s;
    logic [IW-1:0]           r_e, n_e;
    logic [COORD_BITS-1:0]   r_gl, n_gl, r_gt, n_gt, r_gr, n_gr, r_gb, n_gb;
    logic [COORD_BITS-1:0]   r_prev_right, n_prev_right;
    logic [PRODW-1:0]        r_prod;
    logic [THRW-1:0]         r_thr, n_thr;
    logic                    r_rej, n_rej;

    // one kept group waits here until the next is known, so the last flag is right
    t_group                  r_pend, n_pend;
    logic                    r_pend_valid, n_pend_valid;
    t_group                  r_out, n_out;
    logic                    r_out_last, n_out_last;
    logic                    r_out_valid, n_out_valid;

    logic                    cfg_wr;
    logic                    can_store;
    logic                    wr_en;
    logic [PW-1:0]           wr_addr;
    logic [PW-1:0]           rd_addr;
    logic [BOXW-1:0]         wr_data;
    logic [COORD_BITS-1:0]   in_span;
    logic [SUM_BITS:0]       sum_ext;
    logic [FW-1:0]           eff_r;
    logic                    k_ge_r;
    logic                    have_main;
    logic [IW-1:0]           s_begin;
    logic [FW-1:0]           p_begin;
    logic                    work;
    logic [COORD_BITS-1:0]   bl, bt, br, bb;
    logic                    first_box;
    logic [COORD_BITS:0]     gap_diff;
    logic                    gap_bad;
    logic [COORD_BITS-1:0]   grp_w, grp_h;
    logic [MB-1:0]           cnt;
    logic                    aspect_bad;
    logic                    width_bad;
    logic [SUM_BITS-1:0]     mul_a;
    logic [MB-1:0]           mul_b;
    logic [PRODW-1:0]        mul_p;
    logic                    out_free;
    logic                    at_last_box;
    logic                    last_start;
    logic                    step_box;
    logic                    step_start;
    t_group                  cur_group;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        unique case (paddr[3:2])
            REG_MAX_RANGE:    prdata = {{(PDATA_BITS-4){1'b0}}, r_max_range};
            REG_MAX_GAP:      prdata = {{(PDATA_BITS-10){1'b0}}, r_max_gap};
            REG_MAX_ASPECT:   prdata = {{(PDATA_BITS-8){1'b0}}, r_max_aspect};
            REG_WIDTH_FACTOR: prdata = {{(PDATA_BITS-8){1'b0}}, r_width_factor};
            default:          prdata = '0;
        endcase
    end

    assign can_store = (r_gpi < CNT_BITS'(MAX_COMPONENTS));
    assign wr_addr   = (r_fill < FW'(MAX_RANGE)) ? win_addr(r_head, r_fill[PW-1:0]) : r_head;
    assign rd_addr   = win_addr(r_head, r_p_cur);
    assign wr_data   = {i_bottom, i_right, i_top, i_left};
    assign in_span   = (i_bottom > i_top) ? (i_bottom - i_top) : '0;
    assign sum_ext   = {1'b0, r_height_sum} + (SUM_BITS+1)'(in_span);

    always_comb begin
        if (r_max_range == 4'd0) begin
            eff_r = FW'(1);
        end else if (5'(r_max_range) > 5'(MAX_RANGE)) begin
            eff_r = FW'(MAX_RANGE);
        end else begin
            eff_r = FW'(r_max_range);
        end
    end

    assign k_ge_r    = (IW'(r_gpi) >= IW'(eff_r));
    assign have_main = r_stored && k_ge_r;
    assign s_begin   = have_main ? (IW'(r_gpi) - IW'(eff_r) + IW'(1)) :
                       k_ge_r    ? (IW'(r_gpi) - IW'(eff_r) + IW'(2)) : IW'(1);
    assign p_begin   = have_main ? (r_fill - eff_r) :
                       k_ge_r    ? (r_fill - eff_r + FW'(1)) : '0;
    assign work      = have_main || (r_fin && (s_begin <= IW'(r_gpi)));

    assign bl = r_rd[COORD_BITS-1:0];
    assign bt = r_rd[2*COORD_BITS-1:COORD_BITS];
    assign br = r_rd[3*COORD_BITS-1:2*COORD_BITS];
    assign bb = r_rd[4*COORD_BITS-1:3*COORD_BITS];

    assign first_box = (r_p_cur == r_p_start);
    // gaps are signed: overlapping neighbors never fail
    assign gap_diff  = {1'b0, bl} - {1'b0, r_prev_right};
    assign gap_bad   = !gap_diff[COORD_BITS] &&
                       (gap_diff[COORD_BITS-1:0] > COORD_BITS'(r_max_gap));

    assign grp_w      = (r_gr > r_gl) ? (r_gr - r_gl) : '0;
    assign grp_h      = (r_gb > r_gt) ? (r_gb - r_gt) : '0;
    assign cnt        = (r_box_count == '0) ? MB'(1) : MB'(r_box_count);
    assign aspect_bad = (PRODW'({grp_w, 4'b0000}) > r_prod);
    assign width_bad  = ({r_prod, 4'b0000} > (PRODW+4)'(r_thr));
    assign mul_p      = PRODW'(mul_a) * PRODW'(mul_b);

    assign out_free    = !r_out_valid || !i_stall;
    assign at_last_box = (r_p_cur == r_p_last);
    assign last_start  = (r_p_start == r_p_end);

    assign cur_group = '{first_comp: r_s[OUT_IDX_BITS-1:0],
                         last_comp:  r_e[OUT_IDX_BITS-1:0],
                         left:       r_gl,
                         top:        r_gt,
                         right:      r_gr,
                         bottom:     r_gb};

    always_comb begin
        n_max_range    = r_max_range;
        n_max_gap      = r_max_gap;
        n_max_aspect   = r_max_aspect;
        n_width_factor = r_width_factor;
        n_height_sum   = r_height_sum;
        n_box_count    = r_box_count;
        n_fill         = r_fill;
        n_head         = r_head;
        n_gpi          = r_gpi;
        n_state        = r_state;
        n_fin          = r_fin;
        n_stored       = r_stored;
        n_p_start      = r_p_start;
        n_p_cur        = r_p_cur;
        n_p_last       = r_p_last;
        n_p_end        = r_p_end;
        n_s            = r_s;
        n_e            = r_e;
        n_gl           = r_gl;
        n_gt           = r_gt;
        n_gr           = r_gr;
        n_gb           = r_gb;
        n_prev_right   = r_prev_right;
        n_thr          = r_thr;
        n_rej          = r_rej;
        n_pend         = r_pend;
        n_pend_valid   = r_pend_valid;
        n_out          = r_out;
        n_out_last     = r_out_last;
        n_out_valid    = r_out_valid;
        mul_a          = '0;
        mul_b          = '0;
        wr_en          = 1'b0;
        step_box       = 1'b0;
        step_start     = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MAX_RANGE:    n_max_range    = pwdata[3:0];
                REG_MAX_GAP:      n_max_gap      = pwdata[9:0];
                REG_MAX_ASPECT:   n_max_aspect   = pwdata[7:0];
                REG_WIDTH_FACTOR: n_width_factor = pwdata[7:0];
                default: ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_mode) begin
                        if (r_box_count < CNT_BITS'(MAX_COMPONENTS)) begin
                            n_height_sum = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
                            n_box_count  = r_box_count + CNT_BITS'(1);
                        end
                    end else begin
                        n_fin    = i_final_box;
                        n_stored = can_store;
                        if (can_store) begin
                            wr_en = 1'b1;
                            if (r_fill < FW'(MAX_RANGE)) begin
                                n_fill = r_fill + FW'(1);
                            end else begin
                                n_head = win_addr(r_head, PW'(1));
                            end
                            n_gpi = r_gpi + CNT_BITS'(1);
                        end
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                // threshold for the width test, fixed for the whole item
                mul_a     = r_height_sum;
                mul_b     = MB'(r_width_factor);
                n_s       = s_begin;
                n_e       = s_begin;
                n_p_start = PW'(p_begin);
                n_p_cur   = PW'(p_begin);
                n_p_last  = PW'(r_fill - FW'(1));
                n_p_end   = r_fin ? PW'(r_fill - FW'(1)) : PW'(p_begin);
                n_state   = work ? S_THR : S_FLUSH;
            end
            S_THR: begin
                n_thr   = r_prod[THRW-1:0];
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_prev_right = br;
                if (first_box) begin
                    n_gl    = bl;
                    n_gt    = bt;
                    n_gr    = br;
                    n_gb    = bb;
                    n_state = S_EMIT;
                end else begin
                    n_gl = (bl < r_gl) ? bl : r_gl;
                    n_gt = (bt < r_gt) ? bt : r_gt;
                    n_gr = (br > r_gr) ? br : r_gr;
                    n_gb = (bb > r_gb) ? bb : r_gb;
                    // a gap kills this and every longer group from the same start
                    if (gap_bad) begin
                        step_start = 1'b1;
                    end else begin
                        n_state = S_MULA;
                    end
                end
            end
            S_MULA: begin
                mul_a   = SUM_BITS'(grp_h);
                mul_b   = MB'(r_max_aspect);
                n_state = S_MULB;
            end
            S_MULB: begin
                n_rej   = aspect_bad;
                mul_a   = SUM_BITS'(grp_w);
                mul_b   = cnt;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_rej || width_bad) begin
                    step_box = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out       = r_pend;
                        n_out_last  = 1'b0;
                        n_out_valid = 1'b1;
                    end
                    n_pend       = cur_group;
                    n_pend_valid = 1'b1;
                    step_box     = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    if (r_pend_valid) begin
                        n_out        = r_pend;
                        n_out_last   = 1'b1;
                        n_out_valid  = 1'b1;
                        n_pend_valid = 1'b0;
                    end
                    if (r_fin) begin
                        n_height_sum = '0;
                        n_box_count  = '0;
                        n_fill       = '0;
                        n_head       = '0;
                        n_gpi        = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (step_start || (step_box && at_last_box)) begin
            if (last_start) begin
                n_state = S_FLUSH;
            end else begin
                n_p_start = r_p_start + PW'(1);
                n_p_cur   = r_p_start + PW'(1);
                n_s       = r_s + IW'(1);
                n_e       = r_s + IW'(1);
                n_state   = S_READ;
            end
        end else if (step_box) begin
            n_p_cur = r_p_cur + PW'(1);
            n_e     = r_e + IW'(1);
            n_state = S_READ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_range    <= RST_MAX_RANGE;
            r_max_gap      <= RST_MAX_GAP;
            r_max_aspect   <= RST_MAX_ASPECT;
            r_width_factor <= RST_WIDTH_FACTOR;
            r_height_sum   <= '0;
            r_box_count    <= '0;
            r_fill         <= '0;
            r_head         <= '0;
            r_gpi          <= '0;
            r_state        <= S_IDLE;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_max_range    <= n_max_range;
            r_max_gap      <= n_max_gap;
            r_max_aspect   <= n_max_aspect;
            r_width_factor <= n_width_factor;
            r_height_sum   <= n_height_sum;
            r_box_count    <= n_box_count;
            r_fill         <= n_fill;
            r_head         <= n_head;
            r_gpi          <= n_gpi;
            r_state        <= n_state;
            r_pend_valid   <= n_pend_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fin        <= n_fin;
        r_stored     <= n_stored;
        r_p_start    <= n_p_start;
        r_p_cur      <= n_p_cur;
        r_p_last     <= n_p_last;
        r_p_end      <= n_p_end;
        r_s          <= n_s;
        r_e          <= n_e;
        r_gl         <= n_gl;
        r_gt         <= n_gt;
        r_gr         <= n_gr;
        r_gb         <= n_gb;
        r_prev_right <= n_prev_right;
        r_prod       <= mul_p;
        r_thr        <= n_thr;
        r_rej        <= n_rej;
        r_pend       <= n_pend;
        r_out        <= n_out;
        r_out_last   <= n_out_last;
    end

    // box window, circular, oldest entry at r_head
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_win[wr_addr] <= wr_data;
        end
        r_rd <= r_win[rd_addr];
    end

    assign o_valid           = r_out_valid;
    assign o_first_component = r_out.first_comp;
    assign o_last_component  = r_out.last_comp;
    assign o_group_left      = r_out.left;
    assign o_group_top       = r_out.top;
    assign o_group_right     = r_out.right;
    assign o_group_bottom    = r_out.bottom;
    assign o_last            = r_out_last;

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("group left pending after item finished");

    a_not_last_has_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> r_pend_valid)
        else $error("non-final group shown with nothing pending");

    a_window_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FW'(MAX_RANGE)) && (r_gpi <= CNT_BITS'(MAX_COMPONENTS)))
        else $error("window fill or pass index out of range");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state == S_FLUSH) && $past(r_fin) && (r_state == S_IDLE))
        |-> ((r_gpi == '0) && (r_fill == '0) && (r_box_count == '0)))
        else $error("final box did not clear pass state");

endmodule

// ----- bench/group_checker.sv -----
module group_checker
    import cgc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic [PADDR_BITS-1:0]   i_paddr,
    input  logic [PDATA_BITS-1:0]   i_pwdata,
    input  logic [PDATA_BITS-1:0]   i_prdata,
    input  logic                    i_pready,

    input  logic                    i_box_valid,
    input  logic                    i_box_stall,
    input  logic                    i_mode,
    input  logic [COORD_BITS-1:0]   i_left,
    input  logic [COORD_BITS-1:0]   i_top,
    input  logic [COORD_BITS-1:0]   i_right,
    input  logic [COORD_BITS-1:0]   i_bottom,
    input  logic                    i_final_box,

    input  logic                    i_grp_valid,
    input  logic                    i_grp_stall,
    input  logic [OUT_IDX_BITS-1:0] i_first_component,
    input  logic [OUT_IDX_BITS-1:0] i_last_component,
    input  logic [COORD_BITS-1:0]   i_group_left,
    input  logic [COORD_BITS-1:0]   i_group_top,
    input  logic [COORD_BITS-1:0]   i_group_right,
    input  logic [COORD_BITS-1:0]   i_group_bottom,
    input  logic                    i_last,

    output int                      o_mismatches,
    output int                      o_open_groups
);

    localparam int     WINDOW_DEPTH = MAX_RANGE_DEF;
    localparam int     BOX_LIMIT    = MAX_COMPONENTS_DEF;
    localparam longint SUM_FULL     = (longint'(1) << SUM_BITS) - 1;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } t_box;

    typedef struct packed {
        t_group grp;
        logic   last;
    } t_group_result;

    logic [3:0] range_reg;
    logic [9:0] gap_reg;
    logic [7:0] aspect_reg;
    logic [7:0] factor_reg;

    longint        height_sum;
    int            box_count;
    t_box          window [WINDOW_DEPTH];
    int            window_fill;
    int            line_index;
    int            step_groups;
    int            mismatches = 0;
    t_group_result expected_groups [$];

    function automatic t_box box_at(input int newest, input int idx);
        return window[idx - (newest - window_fill + 1)];
    endfunction

    // walks one candidate group and queues it if it survives the gap, aspect and width tests
    function automatic void offer_group(input int newest, input int first, input int span_len);
        t_box          b;
        t_group_result res;
        int            gl, gt, gr, gb, prev_right;
        int            cl, ct, cr, cb, gap_lim;
        longint        w, h, cnt;
        gap_lim = gap_reg;
        b = box_at(newest, first);
        gl = b.left;
        gt = b.top;
        gr = b.right;
        gb = b.bottom;
        prev_right = gr;
        for (int j = 1; j < span_len; j++) begin
            b = box_at(newest, first + j);
            cl = b.left;
            ct = b.top;
            cr = b.right;
            cb = b.bottom;
            if (cl - prev_right > gap_lim) return;
            if (cl < gl) gl = cl;
            if (ct < gt) gt = ct;
            if (cr > gr) gr = cr;
            if (cb > gb) gb = cb;
            prev_right = cr;
        end
        if (span_len > 1) begin
            w = (gr > gl) ? gr - gl : 0;
            h = (gb > gt) ? gb - gt : 0;
            cnt = (box_count != 0) ? box_count : 1;
            if (w * 16 > longint'(aspect_reg) * h) return;
            if (w * cnt * 16 > height_sum * longint'(factor_reg)) return;
        end
        res.grp.first_comp = 13'(first);
        res.grp.last_comp  = 13'(first + span_len - 1);
        res.grp.left       = 16'(gl);
        res.grp.top        = 16'(gt);
        res.grp.right      = 16'(gr);
        res.grp.bottom     = 16'(gb);
        res.last           = 1'b0;
        expected_groups.push_back(res);
        step_groups++;
    endfunction

    function automatic void absorb_box(input logic mode, input t_box nb, input logic fin);
        int     rng, newest, s0;
        bit     stored;
        longint sum;
        step_groups = 0;
        if (!mode) begin
            if (box_count < BOX_LIMIT) begin
                sum = height_sum + ((nb.bottom > nb.top) ? nb.bottom - nb.top : 0);
                height_sum = (sum > SUM_FULL) ? SUM_FULL : sum;
                box_count++;
            end
            return;
        end
        rng = range_reg;
        if (rng < 1) rng = 1;
        if (rng > WINDOW_DEPTH) rng = WINDOW_DEPTH;
        stored = line_index < BOX_LIMIT;
        if (stored) begin
            if (window_fill < WINDOW_DEPTH) begin
                window[window_fill] = nb;
                window_fill++;
            end else begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) window[i] = window[i + 1];
                window[WINDOW_DEPTH - 1] = nb;
            end
            line_index++;
        end
        newest = line_index;
        if (stored && newest >= rng) begin
            for (int g = 1; g <= rng; g++) offer_group(newest, newest - rng + 1, g);
        end
        if (fin) begin
            // flush every later start with all sizes that still fit
            s0 = (newest >= rng) ? newest - rng + 2 : 1;
            for (int s = s0; s <= newest; s++) begin
                for (int g = 1; g <= newest - s + 1; g++) offer_group(newest, s, g);
            end
            height_sum = 0;
            box_count = 0;
            window_fill = 0;
            line_index = 0;
        end
        if (step_groups > 0) expected_groups[expected_groups.size() - 1].last = 1'b1;
    endfunction

    function automatic string group_text(input t_group_result g);
        return $sformatf("comp %0d..%0d box (%0d,%0d)-(%0d,%0d) last %0b",
                         g.grp.first_comp, g.grp.last_comp, g.grp.left, g.grp.top,
                         g.grp.right, g.grp.bottom, g.last);
    endfunction

    function automatic logic [PDATA_BITS-1:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_MAX_RANGE:    return 32'(range_reg);
            REG_MAX_GAP:      return 32'(gap_reg);
            REG_MAX_ASPECT:   return 32'(aspect_reg);
            REG_WIDTH_FACTOR: return 32'(factor_reg);
            default:          return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_box          nb;
        t_group_result got;
        t_group_result want;
        if (!i_rst_n) begin
            range_reg = RST_MAX_RANGE;
            gap_reg = RST_MAX_GAP;
            aspect_reg = RST_MAX_ASPECT;
            factor_reg = RST_WIDTH_FACTOR;
            height_sum = 0;
            box_count = 0;
            window_fill = 0;
            line_index = 0;
            expected_groups.delete();
        end else begin
            if (i_psel && i_penable && i_pready && !i_pwrite) begin
                if (i_prdata !== reg_value(i_paddr[3:2])) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("register %0d read back: expected %0d, got %0d",
                                 i_paddr[3:2], reg_value(i_paddr[3:2]), i_prdata);
                end
            end
            if (i_psel && i_penable && i_pready && i_pwrite) begin
                case (i_paddr[3:2])
                    REG_MAX_RANGE:    range_reg = i_pwdata[3:0];
                    REG_MAX_GAP:      gap_reg = i_pwdata[9:0];
                    REG_MAX_ASPECT:   aspect_reg = i_pwdata[7:0];
                    REG_WIDTH_FACTOR: factor_reg = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_box_valid && !i_box_stall) begin
                nb.left = i_left;
                nb.top = i_top;
                nb.right = i_right;
                nb.bottom = i_bottom;
                absorb_box(i_mode, nb, i_final_box);
            end
            if (i_grp_valid && !i_grp_stall) begin
                got.grp.first_comp = i_first_component;
                got.grp.last_comp  = i_last_component;
                got.grp.left       = i_group_left;
                got.grp.top        = i_group_top;
                got.grp.right      = i_group_right;
                got.grp.bottom     = i_group_bottom;
                got.last           = i_last;
                if (expected_groups.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("group transfer with none expected: %s", group_text(got));
                end else begin
                    want = expected_groups.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("group mismatch: expected %s", group_text(want));
                            $display("                got      %s", group_text(got));
                        end
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_open_groups <= expected_groups.size();
    end

endmodule

// ----- bench/tb.sv -----
module tb;
    import cgc_pkg::*;

    localparam int SETTLE_CYCLES  = 1500;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int RANDOM_BOXES   = 280;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } t_line_box;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_BITS-1:0]   paddr;
    logic [PDATA_BITS-1:0]   pwdata;
    logic [PDATA_BITS-1:0]   prdata;
    logic                    pready;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_mode;
    logic [COORD_BITS-1:0]   i_left;
    logic [COORD_BITS-1:0]   i_top;
    logic [COORD_BITS-1:0]   i_right;
    logic [COORD_BITS-1:0]   i_bottom;
    logic                    i_final_box;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [OUT_IDX_BITS-1:0] o_first_component;
    logic [OUT_IDX_BITS-1:0] o_last_component;
    logic [COORD_BITS-1:0]   o_group_left;
    logic [COORD_BITS-1:0]   o_group_top;
    logic [COORD_BITS-1:0]   o_group_right;
    logic [COORD_BITS-1:0]   o_group_bottom;
    logic                    o_last;

    int group_mismatches;
    int groups_open;
    int boxes_sent = 0;
    int stall_left = 0;
    int sink_wait;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;

    component_group_candidates dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_left            (i_left),
        .i_top             (i_top),
        .i_right           (i_right),
        .i_bottom          (i_bottom),
        .i_final_box       (i_final_box),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_first_component (o_first_component),
        .o_last_component  (o_last_component),
        .o_group_left      (o_group_left),
        .o_group_top       (o_group_top),
        .o_group_right     (o_group_right),
        .o_group_bottom    (o_group_bottom),
        .o_last            (o_last)
    );

    group_checker grp_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_prdata          (prdata),
        .i_pready          (pready),
        .i_box_valid       (i_valid),
        .i_box_stall       (o_stall),
        .i_mode            (i_mode),
        .i_left            (i_left),
        .i_top             (i_top),
        .i_right           (i_right),
        .i_bottom          (i_bottom),
        .i_final_box       (i_final_box),
        .i_grp_valid       (o_valid),
        .i_grp_stall       (i_stall),
        .i_first_component (o_first_component),
        .i_last_component  (o_last_component),
        .i_group_left      (o_group_left),
        .i_group_top       (o_group_top),
        .i_group_right     (o_group_right),
        .i_group_bottom    (o_group_bottom),
        .i_last            (o_last),
        .o_mismatches      (group_mismatches),
        .o_open_groups     (groups_open)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, 5));
    endfunction

    // receiver holds stall for a freshly drawn number of cycles after each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_valid && !i_stall) begin
            sink_wait = draw_wait();
            i_stall <= (sink_wait != 0);
            stall_left <= sink_wait;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("component_group_candidates test failed");
            $finish;
        end
    end

    task automatic send_box(input logic mode, input logic [15:0] l, input logic [15:0] t,
                            input logic [15:0] r, input logic [15:0] b, input logic fin);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_left <= l;
        i_top <= t;
        i_right <= r;
        i_bottom <= b;
        i_final_box <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        boxes_sent++;
    endtask

    // hold off new boxes until every predicted group has been transferred
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (groups_open != 0) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        paddr <= {idx, 2'b00};
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [31:0] rng, input logic [31:0] gap,
                               input logic [31:0] aspect, input logic [31:0] factor);
        drain();
        // a box whose groups are all rejected gives no sign of being done
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        set_reg(REG_MAX_RANGE, rng);
        set_reg(REG_MAX_GAP, gap);
        set_reg(REG_MAX_ASPECT, aspect);
        set_reg(REG_WIDTH_FACTOR, factor);
    endtask

    task automatic random_setting();
        logic [31:0] rng, gap, aspect, factor;
        case ($urandom_range(0, 9))
            0:       rng = 0;
            1:       rng = $urandom_range(9, 15);
            default: rng = $urandom_range(1, 8);
        endcase
        case ($urandom_range(0, 4))
            0:       gap = 0;
            1:       gap = 1023;
            default: gap = $urandom_range(0, 8);
        endcase
        case ($urandom_range(0, 5))
            0:       aspect = 0;
            1:       aspect = 255;
            default: aspect = $urandom_range(16, 200);
        endcase
        case ($urandom_range(0, 5))
            0:       factor = 0;
            1:       factor = 255;
            default: factor = $urandom_range(20, 120);
        endcase
        reconfigure(rng, gap, aspect, factor);
    endtask

    // one text line: optional height pass, then the grouping pass over the same boxes
    task automatic run_line(input int n, input bit heights_first);
        t_line_box line [$];
        t_line_box bx;
        int        x, y0;
        x = $urandom_range(2, 50000);
        y0 = $urandom_range(0, 60000);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                bx.left = 16'($urandom);
                bx.top = 16'($urandom);
                bx.right = 16'($urandom);
                bx.bottom = 16'($urandom);
            end else begin
                x = x + $urandom_range(0, 8) - 2;
                bx.left = 16'(x);
                bx.top = 16'(y0 + $urandom_range(0, 8));
                x = x + $urandom_range(1, 30);
                bx.right = 16'(x);
                bx.bottom = 16'(bx.top + $urandom_range(8, 40));
            end
            line.push_back(bx);
        end
        if (heights_first) begin
            foreach (line[i])
                send_box(1'b0, line[i].left, line[i].top, line[i].right, line[i].bottom,
                         i == line.size() - 1);
        end
        foreach (line[i]) begin
            if ($urandom_range(0, 15) == 0) drain();
            if ($urandom_range(0, 19) == 0)
                send_box(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom));
            send_box(1'b1, line[i].left, line[i].top, line[i].right, line[i].bottom,
                     (i == line.size() - 1) || ($urandom_range(0, 29) == 0));
        end
    endtask

    initial begin
        int random_start;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_mode = 1'b0;
        i_left = '0;
        i_top = '0;
        i_right = '0;
        i_bottom = '0;
        i_final_box = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: inverted boxes, overlap, wide gap, height box inside the grouping pass
        send_box(1'b0, 16'd0, 16'd0, 16'd10, 16'd20, 1'b0);
        send_box(1'b0, 16'd3, 16'd40, 16'd9, 16'd10, 1'b0);
        send_box(1'b0, 16'd0, 16'd0, 16'd65535, 16'd65535, 1'b1);
        send_box(1'b1, 16'd0, 16'd0, 16'd10, 16'd20, 1'b0);
        send_box(1'b1, 16'd11, 16'd2, 16'd20, 16'd22, 1'b0);
        send_box(1'b1, 16'd18, 16'd0, 16'd30, 16'd20, 1'b0);
        send_box(1'b0, 16'd0, 16'd100, 16'd0, 16'd130, 1'b0);
        send_box(1'b1, 16'd33, 16'd0, 16'd40, 16'd21, 1'b0);
        send_box(1'b1, 16'd41, 16'd65535, 16'd50, 16'd0, 1'b0);
        drain();
        send_box(1'b1, 16'd65535, 16'd0, 16'd65535, 16'd65535, 1'b1);

        // grouping pass with no height pass before it
        reconfigure(2, 1023, 255, 255);
        send_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd10, 1'b0);
        send_box(1'b1, 16'd0, 16'd0, 16'd0, 16'd12, 1'b0);
        send_box(1'b1, 16'd5, 16'd0, 16'd9, 16'd10, 1'b1);

        // range above the window acts as the full window; final box gives the most groups
        reconfigure(15, 1023, 255, 255);
        send_box(1'b0, 16'd0, 16'd0, 16'd10, 16'd65535, 1'b0);
        send_box(1'b0, 16'd20, 16'd0, 16'd30, 16'd65535, 1'b0);
        for (int i = 0; i < 10; i++)
            send_box(1'b1, 16'(20 * i), 16'd0, 16'(20 * i + 15), 16'd65535, i == 9);

        // range zero, then a larger range in the middle of the pass
        reconfigure(0, 1023, 255, 255);
        send_box(1'b1, 16'd0, 16'd0, 16'd5, 16'd10, 1'b0);
        send_box(1'b1, 16'd6, 16'd0, 16'd11, 16'd10, 1'b0);
        reconfigure(3, 1023, 255, 255);
        send_box(1'b1, 16'd12, 16'd0, 16'd17, 16'd10, 1'b0);
        send_box(1'b1, 16'd18, 16'd0, 16'd23, 16'd10, 1'b1);

        // zero limits: only single boxes and zero-width groups survive
        reconfigure(2, 0, 0, 0);
        send_box(1'b1, 16'd100, 16'd0, 16'd100, 16'd10, 1'b0);
        send_box(1'b1, 16'd100, 16'd5, 16'd100, 16'd20, 1'b0);
        send_box(1'b1, 16'd101, 16'd0, 16'd110, 16'd10, 1'b1);

        random_start = boxes_sent;
        while (boxes_sent < random_start + RANDOM_BOXES) begin
            random_setting();
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5))
                run_line(($urandom_range(0, 7) == 0) ? $urandom_range(1, 20)
                                                     : $urandom_range(1, 10),
                         $urandom_range(0, 5) != 0);
        end
        no_idle = 1'b0;

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (group_mismatches == 0 && groups_open == 0)
            $display("component_group_candidates test passed");
        else
            $display("component_group_candidates test failed");
        $finish;
    end

endmodule
